/* rtl/core/sbmq_pkg.sv */
// ============================================================================
// Shared buffer multi-queue package
// Sizes, codes and structures shared by the front end, the back end and
// the top level of the shared buffer multi-queue.
// ============================================================================
package sbmq_pkg;

  // Store and queue sizes.
  localparam int CAPACITY   = 8;
  localparam int NUM_QUEUES = 4;

  // Slot index and queue index widths.
  localparam int SW = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
  localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;

  // Fixed field widths of the stream channels.
  localparam int KIND_W  = 2;
  localparam int QID_W   = 2;
  localparam int VALUE_W = 32;
  localparam int STAT_W  = 2;

  // Depth of the command queue between front and back end.
  localparam int CMD_DEPTH = 2;
  localparam int CPW       = (CMD_DEPTH > 2) ? $clog2(CMD_DEPTH) : 1;
  localparam int CCW       = $clog2(CMD_DEPTH + 1);

  // Request kinds as they arrive on the input channel.
  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH = 2'd0,
    KIND_POP  = 2'd1,
    KIND_PEEK = 2'd2
  } kind_t;

  // Result status codes.
  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Classified command handed from the front end to the back end.
  typedef enum logic [2:0] {
    CMD_PUSH,
    CMD_POP,
    CMD_PEEK,
    CMD_DONE,
    CMD_FULL,
    CMD_EMPTY
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t              op;
    logic [QW-1:0]        q;
    logic [VALUE_W-1:0]   value;
  } cmd_t;

  // Slot pointer with a valid bit; a cleared valid bit is a null pointer.
  typedef struct packed {
    logic          vld;
    logic [SW-1:0] idx;
  } ptr_t;

endpackage

/* rtl/core/sbmq_front.sv */
// ============================================================================
// Shared buffer multi-queue front end
// Accepts requests, classifies them into commands and holds them in a
// short command queue for the back end.
// ============================================================================
module sbmq_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [sbmq_pkg::VALUE_W-1:0] in_tdata,
  input  logic [3:0]                   in_tuser,
  output logic                         cmd_vld,
  output sbmq_pkg::cmd_t               cmd,
  input  logic                         cmd_take
);
  import sbmq_pkg::*;

  cmd_t             cls_cmd;
  logic             q_ok;
  logic             wr_en;
  cmd_t             fifo_r [CMD_DEPTH];
  logic [CPW-1:0]   wr_ptr_r;
  logic [CPW-1:0]   wr_ptr_nxt;
  logic [CPW-1:0]   rd_ptr_r;
  logic [CPW-1:0]   rd_ptr_nxt;
  logic [CCW-1:0]   cnt_r;
  logic [CCW-1:0]   cnt_nxt;

  // Queue ids beyond the configured count are turned away here.
  assign q_ok = (32'(in_tuser[3:2]) < NUM_QUEUES);

  always_comb begin
    cls_cmd.q     = QW'(in_tuser[3:2]);
    cls_cmd.value = in_tdata;
    case (kind_t'(in_tuser[1:0]))
      KIND_PUSH: cls_cmd.op = q_ok ? CMD_PUSH : CMD_FULL;
      KIND_POP:  cls_cmd.op = q_ok ? CMD_POP  : CMD_EMPTY;
      KIND_PEEK: cls_cmd.op = q_ok ? CMD_PEEK : CMD_EMPTY;
      default:   cls_cmd.op = CMD_DONE;
    endcase
  end

  assign in_tready = (cnt_r != CCW'(CMD_DEPTH));
  assign wr_en     = in_tvalid && in_tready;
  assign cmd_vld   = (cnt_r != '0);
  assign cmd       = fifo_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == CPW'(CMD_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (cmd_take) begin
      rd_ptr_nxt = (rd_ptr_r == CPW'(CMD_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (wr_en && !cmd_take) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!wr_en && cmd_take) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fifo_r[wr_ptr_r] <= cls_cmd;
    end
  end

endmodule

/* rtl/core/sbmq_back.sv */
// ============================================================================
// Shared buffer multi-queue back end
// Executes commands against the list pointers and the shared data store,
// and drives the result register.
// ============================================================================
module sbmq_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cmd_vld,
  input  sbmq_pkg::cmd_t               cmd,
  output logic                         cmd_take,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [sbmq_pkg::VALUE_W-1:0] out_tdata,
  output logic [sbmq_pkg::STAT_W-1:0]  out_tuser
);
  import sbmq_pkg::*;

  ptr_t               free_r;
  ptr_t               free_nxt;
  ptr_t               head_r [NUM_QUEUES];
  ptr_t               head_nxt [NUM_QUEUES];
  ptr_t               tail_r [NUM_QUEUES];
  ptr_t               tail_nxt [NUM_QUEUES];
  ptr_t               link_r [CAPACITY];
  ptr_t               link_nxt [CAPACITY];
  logic [VALUE_W-1:0] slot_data_mem [CAPACITY];
  logic [VALUE_W-1:0] rd_data_r;

  logic               issue;
  logic               wr_en;
  logic               rd_en;
  logic [SW-1:0]      wr_idx;
  logic [SW-1:0]      rd_idx;
  status_t            st;

  logic               p_vld_r;
  status_t            p_status_r;
  logic               p_rd_r;
  logic               out_vld_r;
  status_t            out_status_r;
  logic [VALUE_W-1:0] out_data_r;

  // A command issues when the read stage is free and the result register
  // is empty or is handing its result to the output.
  assign issue    = cmd_vld && !p_vld_r && (!out_vld_r || out_tready);
  assign cmd_take = issue;
  assign rd_idx   = head_r[cmd.q].idx;
  assign wr_idx   = free_r.idx;

  always_comb begin
    free_nxt = free_r;
    head_nxt = head_r;
    tail_nxt = tail_r;
    link_nxt = link_r;
    wr_en    = 1'b0;
    rd_en    = 1'b0;
    st       = ST_DONE;
    if (issue) begin
      case (cmd.op)
        CMD_PUSH: begin
          if (!free_r.vld) begin
            st = ST_FULL;
          end else begin
            wr_en    = 1'b1;
            free_nxt = link_r[free_r.idx];
            if (!head_r[cmd.q].vld) begin
              head_nxt[cmd.q] = '{vld: 1'b1, idx: free_r.idx};
            end else if (tail_r[cmd.q].vld) begin
              link_nxt[tail_r[cmd.q].idx] = '{vld: 1'b1, idx: free_r.idx};
            end
            link_nxt[free_r.idx] = '{vld: 1'b0, idx: '0};
            tail_nxt[cmd.q]      = '{vld: 1'b1, idx: free_r.idx};
          end
        end
        CMD_POP: begin
          if (!head_r[cmd.q].vld) begin
            st = ST_EMPTY;
          end else begin
            rd_en            = 1'b1;
            head_nxt[cmd.q]  = link_r[rd_idx];
            link_nxt[rd_idx] = free_r;
            free_nxt         = '{vld: 1'b1, idx: rd_idx};
          end
        end
        CMD_PEEK: begin
          if (!head_r[cmd.q].vld) begin
            st = ST_EMPTY;
          end else begin
            rd_en = 1'b1;
          end
        end
        CMD_FULL:  st = ST_FULL;
        CMD_EMPTY: st = ST_EMPTY;
        default:   st = ST_DONE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_r <= '{vld: 1'b1, idx: '0};
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head_r[i] <= '{vld: 1'b0, idx: '0};
        tail_r[i] <= '{vld: 1'b0, idx: '0};
      end
      for (int i = 0; i < CAPACITY; i++) begin
        link_r[i] <= '{vld: ((i + 1) < CAPACITY), idx: SW'(i + 1)};
      end
    end else begin
      free_r <= free_nxt;
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      link_r <= link_nxt;
    end
  end

  // Shared data store with a registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_data_mem[wr_idx] <= cmd.value;
    end
    if (rd_en) begin
      rd_data_r <= slot_data_mem[rd_idx];
    end
  end

  // Read stage and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      p_vld_r <= issue;
      if (p_vld_r) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      p_status_r <= st;
      p_rd_r     <= rd_en;
    end
    if (p_vld_r) begin
      out_status_r <= p_status_r;
      out_data_r   <= p_rd_r ? rd_data_r : '0;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;

endmodule

/* rtl/core/shared_buffer_multi_queue.sv */
// ============================================================================
// Shared buffer multi-queue
// Several FIFO queues kept as linked lists in one shared slot store, with
// unused slots on a free list. Requests push, pop or peek one queue.
// ============================================================================
//
// Channel  Direction  Transfer moves
// in_      slave      one request: kind, queue id and push value
// out_     master     one result: status and popped or peeked value
//
// Each request first updates the list pointers and addresses the data store;
// the store's registered read then lands in the result register. A new
// request does not issue while the previous one is still in the read stage.
// The link list is loaded by reset, with no clearing pass.
// A stalled result stops request transfers only once the command queue fills:
// up to two requests wait there while the result register holds.
module shared_buffer_multi_queue (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // in_tdata: [31:0] value
  input  logic [sbmq_pkg::VALUE_W-1:0] in_tdata,
  // in_tuser: [1:0] kind, [3:2] queue_id
  input  logic [3:0]                   in_tuser,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // out_tdata: [31:0] data
  output logic [sbmq_pkg::VALUE_W-1:0] out_tdata,
  // out_tuser: [1:0] status
  output logic [sbmq_pkg::STAT_W-1:0]  out_tuser
);
  import sbmq_pkg::*;

  logic cmd_vld;
  cmd_t cmd;
  logic cmd_take;

  // The front end classifies each request, including unused kinds and
  // out of range queue ids, so the back end only sees clean commands.
  sbmq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd_vld   (cmd_vld),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  // The back end owns all list pointers and the data store.
  sbmq_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_vld    (cmd_vld),
    .cmd        (cmd),
    .cmd_take   (cmd_take),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

/* rtl/core/sbmq_checker.sv */
// ============================================================================
// Shared buffer multi-queue checker
// Port-level checks on the result channel and on the idle state after reset,
// bound to the top level.
module sbmq_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_tready,
  input logic                         out_tvalid,
  input logic                         out_tready,
  input logic [sbmq_pkg::VALUE_W-1:0] out_tdata,
  input logic [sbmq_pkg::STAT_W-1:0]  out_tuser
);
  import sbmq_pkg::*;

  // Reset leaves an empty command queue and no pending result.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> in_tready && !out_tvalid)
    else $error("block not idle after reset");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == ST_DONE || out_tuser == ST_FULL ||
                    out_tuser == ST_EMPTY))
    else $error("unknown result status");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_DONE |-> out_tdata == '0)
    else $error("failed request returned nonzero data");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
                                  $stable(out_tuser))
    else $error("stalled result changed");

endmodule

bind shared_buffer_multi_queue sbmq_checker u_sbmq_checker (.*);

/* tb/tb_shared_buffer_multi_queue.sv */
// ============================================================================
// Shared buffer multi-queue testbench
// Drives push, pop and peek requests into the shared buffer multi-queue,
// predicts each result from a private copy of the slot store, link list,
// queue pointers and free list, and checks every result transfer in order.
// ============================================================================
module tb_shared_buffer_multi_queue;
  import sbmq_pkg::*;

  // The block has no code for the spare request kind; it must answer it
  // with a plain done and leave everything alone.
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS = 1600;
  // The final part of the random run goes without idling on either side.
  localparam int QUIET_FROM   = 1400;
  localparam int MAX_REPORTS  = 10;

  // One predicted result: status and data word.
  typedef struct {
    logic [STAT_W-1:0]  status;
    logic [VALUE_W-1:0] data;
  } queue_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: keeps its own picture of the linked queues and the free list,
  // turns every accepted request into the result the block owes, and matches
  // result transfers against those predictions oldest first.
  // --------------------------------------------------------------------------
  class sbmq_scoreboard;
    logic [VALUE_W-1:0] slot_data [CAPACITY];
    ptr_t               slot_next [CAPACITY];
    ptr_t               head_of   [NUM_QUEUES];
    ptr_t               tail_of   [NUM_QUEUES];
    ptr_t               free_list;
    queue_result_t      owed_results[$];
    int                 mismatches;

    function new();
      for (int i = 0; i < CAPACITY; i++) begin
        slot_data[i]     = '0;
        slot_next[i].idx = SW'((i + 1) % CAPACITY);
        slot_next[i].vld = (i + 1 < CAPACITY);
      end
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head_of[i] = '0;
        tail_of[i] = '0;
      end
      free_list.idx = '0;
      free_list.vld = 1'b1;
      mismatches    = 0;
    endfunction

    // Applies one accepted request to the predicted state and queues up
    // the result it must produce.
    function void note_request(logic [KIND_W-1:0] kind, logic [QID_W-1:0] qid,
                               logic [VALUE_W-1:0] value);
      queue_result_t r;
      ptr_t          slot;
      r.status = ST_DONE;
      r.data   = '0;
      if (kind == KIND_UNUSED) begin
        r.status = ST_DONE;
      end else if (int'(qid) >= NUM_QUEUES) begin
        r.status = (kind == KIND_PUSH) ? ST_FULL : ST_EMPTY;
      end else if (kind == KIND_PUSH) begin
        if (!free_list.vld) begin
          r.status = ST_FULL;
        end else begin
          slot            = free_list;
          free_list       = slot_next[slot.idx];
          slot_data[slot.idx] = value;
          // A drained queue keeps a stale tail, so the head decides whether
          // the list restarts or grows behind the tail.
          if (!head_of[qid].vld) begin
            head_of[qid] = slot;
          end else if (tail_of[qid].vld) begin
            slot_next[tail_of[qid].idx] = slot;
          end
          slot_next[slot.idx] = '0;
          tail_of[qid]        = slot;
        end
      end else begin
        if (!head_of[qid].vld) begin
          r.status = ST_EMPTY;
        end else begin
          slot   = head_of[qid];
          r.data = slot_data[slot.idx];
          if (kind == KIND_POP) begin
            head_of[qid]        = slot_next[slot.idx];
            slot_next[slot.idx] = free_list;
            free_list           = slot;
          end
        end
      end
      owed_results.push_back(r);
    endfunction

    function void check_result(logic [STAT_W-1:0] status, logic [VALUE_W-1:0] data);
      queue_result_t want;
      if (owed_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("ERROR: result with nothing owed: status %0d data %h", status, data);
        return;
      end
      want = owed_results.pop_front();
      if (status !== want.status || data !== want.data) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("ERROR: status exp %0d got %0d, data exp %h got %h",
                   want.status, status, want.data, data);
      end
    endfunction

    function int owed_count();
      return owed_results.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [VALUE_W-1:0] in_tdata = '0;
  logic [3:0]         in_tuser = '0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [VALUE_W-1:0] out_tdata;
  logic [STAT_W-1:0]  out_tuser;

  // Set for the last stretch of the run, when neither side idles.
  logic               no_idle = 1'b0;

  sbmq_scoreboard sb = new();

  shared_buffer_multi_queue dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Offers one request from the next falling edge and holds it until the
  // transfer happens. Valid stays high afterwards so back-to-back requests
  // need no dead cycle; a gap or a pause lowers it.
  task automatic send_request(logic [KIND_W-1:0] kind, logic [QID_W-1:0] qid,
                              logic [VALUE_W-1:0] value);
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tuser  = {qid, kind};
    in_tdata  = value;
    do @(posedge clk); while (!in_tready);
    sb.note_request(kind, qid, value);
  endtask

  task automatic idle_input(int cycles);
    @(negedge clk);
    in_tvalid = 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // Holds off the input until every owed result has been delivered.
  task automatic hold_until_drained();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (sb.owed_count() != 0) @(posedge clk);
  endtask

  // Result side: ready drops at random for a random stretch, and stays high while no_idle is set.
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (no_idle) begin
        out_tready = 1'b1;
      end else if (stall_left > 0) begin
        out_tready = 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 11) == 0) begin
        out_tready = 1'b0;
        stall_left = $urandom_range(1, 10) - 1;
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  // Every result transfer is checked against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tuser, out_tdata);
  end

  initial begin
    int                 push_pct;
    int                 favored_q;
    int                 pick;
    logic [KIND_W-1:0]  kind;
    logic [QID_W-1:0]   qid;
    logic [VALUE_W-1:0] value;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part. Pop and peek on empty queues, the unused kind, then fill
    // every slot with the extreme data words so the next push finds the
    // store full.
    send_request(KIND_POP,    2'd0, 32'h0000_0000);
    send_request(KIND_PEEK,   2'd3, 32'hFFFF_FFFF);
    send_request(KIND_UNUSED, 2'd1, 32'h1234_5678);
    send_request(KIND_PUSH,   2'd0, 32'h8000_0000);
    send_request(KIND_PUSH,   2'd0, 32'h7FFF_FFFF);
    send_request(KIND_PUSH,   2'd1, 32'h0000_0000);
    send_request(KIND_PUSH,   2'd1, 32'hFFFF_FFFF);
    send_request(KIND_PUSH,   2'd2, 32'h5555_5555);
    send_request(KIND_PUSH,   2'd3, 32'hAAAA_AAAA);
    send_request(KIND_PUSH,   2'd3, 32'h0000_0001);
    send_request(KIND_PUSH,   2'd2, $urandom);
    send_request(KIND_PUSH,   2'd0, 32'hDEAD_BEEF);
    // Drain queue 0 completely; it keeps a stale tail, and the push after
    // that must restart the list from its head.
    send_request(KIND_PEEK,   2'd0, 32'h0);
    send_request(KIND_POP,    2'd0, 32'h0);
    send_request(KIND_POP,    2'd0, 32'h0);
    send_request(KIND_POP,    2'd0, 32'h0);
    send_request(KIND_PUSH,   2'd0, 32'hC001_D00D);
    send_request(KIND_PEEK,   2'd0, 32'h0);
    send_request(KIND_POP,    2'd1, 32'h0);
    send_request(KIND_POP,    2'd1, 32'h0);
    send_request(KIND_POP,    2'd2, 32'h0);
    send_request(KIND_POP,    2'd3, 32'h0);
    send_request(KIND_UNUSED, 2'd2, 32'hFFFF_FFFF);
    hold_until_drained();

    // Random part. Every hundred requests the push share and a favored queue
    // change, so the store swings between full and nearly empty and single
    // queues grow long chains through the shared links.
    push_pct  = 50;
    favored_q = 0;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 100 == 0) begin
        case ($urandom_range(0, 2))
          0: begin
            push_pct = 20;
          end
          1: begin
            push_pct = 50;
          end
          default: begin
            push_pct = 80;
          end
        endcase
        favored_q = $urandom_range(0, NUM_QUEUES - 1);
      end
      if (i == QUIET_FROM)
        no_idle = 1'b1;
      if (i == RANDOM_ITEMS / 2)
        hold_until_drained();

      pick = $urandom_range(0, 99);
      if (pick < 3)
        kind = KIND_UNUSED;
      else if ($urandom_range(0, 99) < push_pct)
        kind = KIND_PUSH;
      else if ($urandom_range(0, 9) < 7)
        kind = KIND_POP;
      else
        kind = KIND_PEEK;

      qid = ($urandom_range(0, 1) == 0) ? QID_W'(favored_q) : QID_W'($urandom_range(0, 3));

      case ($urandom_range(0, 15))
        0: begin
          value = 32'h8000_0000;
        end
        1: begin
          value = 32'h7FFF_FFFF;
        end
        default: begin
          value = $urandom;
        end
      endcase

      send_request(kind, qid, value);
      if (!no_idle && $urandom_range(0, 7) == 0)
        idle_input($urandom_range(1, 10));
    end

    @(negedge clk);
    in_tvalid = 1'b0;
    while (sb.owed_count() != 0) @(posedge clk);
    // Run on so that a stray extra result would still be caught.
    repeat (20) @(posedge clk);

    if (sb.mismatches == 0 && sb.owed_count() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run.
  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule
